// ===== hw/rtl/ble_dedup_pkg.sv =====
package ble_dedup_pkg;

   localparam int MaxDevices = 32;
   localparam int NameBytes  = 32;
   localparam int IdxW       = $clog2(MaxDevices);
   localparam int PosW       = $clog2(NameBytes);
   localparam int CntW       = $clog2(MaxDevices + 1);

   typedef enum logic [1:0] {
      CMD_ADV   = 2'd0,
      CMD_CLEAR = 2'd1,
      CMD_READ  = 2'd2,
      CMD_NONE  = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      ST_UPDATED  = 3'd0,
      ST_INSERTED = 3'd1,
      ST_DROPPED  = 3'd2,
      ST_READ     = 3'd3,
      ST_EMPTY    = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      PH_LEN  = 2'd0,
      PH_TYPE = 2'd1,
      PH_DATA = 2'd2,
      PH_STOP = 2'd3
   } phase_type;

   typedef enum logic [2:0] {
      S_IDLE   = 3'd0,
      S_SEARCH = 3'd1,
      S_COPY   = 3'd2,
      S_READ   = 3'd3,
      S_OUT    = 3'd4
   } fsm_type;

   // Control handed to every cell in the table chain.
   typedef struct packed {
      logic            shift;     // rotate address row by one cell
      logic            load_addr; // write address at write index
      logic [IdxW-1:0] wr_index;
      logic [47:0]     addr;
   } cell_ctl_type;

endpackage

// ===== hw/rtl/ble_dedup_cell.sv =====
module ble_dedup_cell (
   input  logic                      clock,
   input  ble_dedup_pkg::cell_ctl_type ctl,
   input  logic [ble_dedup_pkg::IdxW-1:0] my_index,
   input  logic [47:0]               prev_addr,
   output logic [47:0]               addr_out
);

   logic [47:0] addr_ff;
   logic [47:0] addr_in;

   always_comb begin
      addr_in = addr_ff;
      if (ctl.shift) begin
         addr_in = prev_addr;
      end else if (ctl.load_addr && ctl.wr_index == my_index) begin
         addr_in = ctl.addr;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff <= addr_in;
   end

   assign addr_out = addr_ff;

endmodule

// ===== hw/rtl/ble_dedup_parser.sv =====
module ble_dedup_parser (
   input  logic        clock,
   input  logic        reset,
   input  logic        step,
   input  logic        restart,
   input  logic [7:0]  data_byte,
   input  logic [7:0]  report_length,
   input  logic [ble_dedup_pkg::PosW-1:0] rd_pos,
   output logic [7:0]  rd_byte,
   output logic [ble_dedup_pkg::PosW:0] name_count
);

   localparam int PosW = ble_dedup_pkg::PosW;
   localparam int NameBytes = ble_dedup_pkg::NameBytes;

   ble_dedup_pkg::phase_type phase_ff, phase_in;
   logic [7:0] pos_ff, pos_in, next_ff, next_in, flen_ff, flen_in;
   logic [PosW:0] cnt_ff, cnt_in;
   logic closed_ff, closed_in, in_name_ff, in_name_in;
   logic wr_en;
   logic [7:0] wr_data;
   logic [7:0] buf_mem [NameBytes];
   logic [8:0] p1, hdr_end;
   logic [7:0] n;

   always_comb begin
      phase_in = phase_ff; pos_in = pos_ff; next_in = next_ff; flen_in = flen_ff;
      cnt_in = cnt_ff; closed_in = closed_ff; in_name_in = in_name_ff;
      wr_en = 1'b0;
      wr_data = (data_byte < 8'h20 || data_byte == 8'h7F) ? 8'h3F : data_byte;
      p1 = {1'b0, pos_ff} + 9'd1;
      hdr_end = p1 + {1'b0, data_byte};
      n = flen_ff - 8'd1;
      if (restart) begin
         phase_in = ble_dedup_pkg::PH_LEN; pos_in = '0; next_in = '0; flen_in = '0;
         cnt_in = '0; closed_in = 1'b0; in_name_in = 1'b0;
      end else if (step) begin
         if (pos_ff < report_length) begin
            case (phase_ff)
               ble_dedup_pkg::PH_LEN: begin
                  if (p1 >= {1'b0, report_length} || data_byte == 8'd0 ||
                      hdr_end > {1'b0, report_length}) begin
                     phase_in = ble_dedup_pkg::PH_STOP;
                  end else begin
                     next_in = hdr_end[7:0];
                     flen_in = data_byte;
                     phase_in = ble_dedup_pkg::PH_TYPE;
                  end
               end
               ble_dedup_pkg::PH_TYPE: begin
                  in_name_in = (data_byte == 8'h09 || data_byte == 8'h08);
                  if (in_name_in) begin
                     flen_in = (n > 8'(NameBytes - 1)) ? 8'(NameBytes - 1) : n;
                  end
                  if (p1 >= {1'b0, next_ff}) begin
                     phase_in = in_name_in ? ble_dedup_pkg::PH_STOP : ble_dedup_pkg::PH_LEN;
                  end else begin
                     phase_in = ble_dedup_pkg::PH_DATA;
                  end
               end
               ble_dedup_pkg::PH_DATA: begin
                  if (in_name_ff && flen_ff != 8'd0) begin
                     flen_in = flen_ff - 8'd1;
                     if (!closed_ff) begin
                        if (data_byte == 8'd0) begin
                           closed_in = 1'b1;
                        end else if (cnt_ff < (PosW+1)'(NameBytes)) begin
                           wr_en = 1'b1;
                           cnt_in = cnt_ff + 1'b1;
                        end
                     end
                  end
                  if (p1 >= {1'b0, next_ff}) begin
                     phase_in = in_name_ff ? ble_dedup_pkg::PH_STOP : ble_dedup_pkg::PH_LEN;
                  end
               end
               default: ;
            endcase
         end
         if (pos_ff != 8'd255) pos_in = pos_ff + 8'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= ble_dedup_pkg::PH_LEN; pos_ff <= '0; next_ff <= '0; flen_ff <= '0;
         cnt_ff <= '0; closed_ff <= 1'b0; in_name_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in; pos_ff <= pos_in; next_ff <= next_in; flen_ff <= flen_in;
         cnt_ff <= cnt_in; closed_ff <= closed_in; in_name_ff <= in_name_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) buf_mem[cnt_ff[PosW-1:0]] <= wr_data;
      rd_byte <= buf_mem[rd_pos];
   end

   assign name_count = cnt_ff;

endmodule

// ===== hw/rtl/ble_adv_name_dedup_table_core.sv =====
// An advertisement byte that is not the last of its report is taken with no response. A last
// byte walks the address cell chain one cell a cycle and turns it back home, then, unless the
// report is dropped, copies the name buffer one byte a cycle; its response, like a read
// response, passes S_READ and then S_OUT, which loads the response register. A clear is taken
// with no response. One request is in work at a time; a waiting response holds off only the
// next response. Synchronous active-high reset clears count, parser and control.
module ble_adv_name_dedup_table_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // sender_addr[47:0], sender_rssi[55:48], report_length[63:56], data_byte[71:64],
   // read_index[76:72], name_pos[81:77], zero fill to 88
   input  logic [87:0] req_tdata,
   // cmd[1:0]
   input  logic [1:0]  req_tuser,
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // entry_count[5:0], entry_addr[53:6], entry_rssi[61:54], name_byte[69:62],
   // name_length[74:70], zero fill to 80
   output logic [79:0] rsp_tdata,
   // status[2:0]
   output logic [2:0]  rsp_tuser
);

   localparam int IdxW = ble_dedup_pkg::IdxW;
   localparam int PosW = ble_dedup_pkg::PosW;
   localparam int CntW = ble_dedup_pkg::CntW;
   localparam int MaxDevices = ble_dedup_pkg::MaxDevices;
   localparam int NameBytes = ble_dedup_pkg::NameBytes;

   ble_dedup_pkg::cmd_type cmd;
   logic [47:0] s_addr;
   logic [7:0]  s_rssi, s_len, s_byte;
   logic [4:0]  s_ridx, s_rpos;

   assign cmd    = ble_dedup_pkg::cmd_type'(req_tuser);
   assign s_addr = req_tdata[47:0];
   assign s_rssi = req_tdata[55:48];
   assign s_len  = req_tdata[63:56];
   assign s_byte = req_tdata[71:64];
   assign s_ridx = req_tdata[76:72];
   assign s_rpos = req_tdata[81:77];

   ble_dedup_pkg::fsm_type state_ff, state_in;
   logic [CntW-1:0] count_ff, count_in;
   logic [CntW-1:0] k_ff, k_in;
   logic [PosW:0]   c_ff, c_in;
   logic [IdxW-1:0] hit_ff, hit_in;
   logic [47:0] addr_ff, addr_in;
   logic [7:0]  rssi_ff, rssi_in;
   logic [4:0]  rpos_ff, rpos_in;
   logic [IdxW-1:0] ridx_ff, ridx_in;
   logic        rsp_v_ff, rsp_v_in;
   logic [79:0] rsp_d_ff, rsp_d_in;
   logic [2:0]  rsp_u_ff, rsp_u_in;
   ble_dedup_pkg::status_type st_ff, st_in;

   logic accept, adv_step, restart;
   logic [PosW:0] ncount;
   logic [7:0] buf_byte;
   logic [PosW-1:0] buf_pos;
   ble_dedup_pkg::cell_ctl_type ctl;
   logic [47:0] cell_addr [MaxDevices];

   // Per-entry memories.
   logic [7:0] rssi_mem [MaxDevices];
   logic [4:0] nlen_mem [MaxDevices];
   logic [7:0] name_mem [MaxDevices*NameBytes];
   logic       rssi_we, nlen_we, name_we;
   logic [IdxW-1:0] mem_idx;
   logic [4:0] nlen_wd;
   logic [7:0] rssi_rd, name_rd;
   logic [4:0] nlen_rd;
   logic [IdxW-1:0] rd_idx;
   logic [PosW-1:0] rd_pos;

   assign accept = req_tvalid && req_tready;
   assign req_tready = (state_ff == ble_dedup_pkg::S_IDLE);
   assign adv_step = accept && cmd == ble_dedup_pkg::CMD_ADV;

   ble_dedup_parser u_parser (
      .clock, .reset, .step(adv_step), .restart,
      .data_byte(s_byte), .report_length(s_len),
      .rd_pos(buf_pos), .rd_byte(buf_byte), .name_count(ncount)
   );

   // Address cells rotate during a search; cell 0 is compared each cycle.
   for (genvar g = 0; g < MaxDevices; g++) begin : g_cell
      ble_dedup_cell u_cell (
         .clock, .ctl, .my_index(IdxW'(g)),
         .prev_addr(cell_addr[(g + 1) % MaxDevices]),
         .addr_out(cell_addr[g])
      );
   end

   always_comb begin
      state_in = state_ff; count_in = count_ff; k_in = k_ff; c_in = c_ff;
      hit_in = hit_ff; addr_in = addr_ff; rssi_in = rssi_ff; rpos_in = rpos_ff;
      ridx_in = ridx_ff; st_in = st_ff; rsp_v_in = rsp_v_ff; rsp_d_in = rsp_d_ff;
      rsp_u_in = rsp_u_ff;
      restart = 1'b0;
      ctl = '{shift: 1'b0, load_addr: 1'b0, wr_index: hit_ff, addr: addr_ff};
      rssi_we = 1'b0; nlen_we = 1'b0; name_we = 1'b0;
      mem_idx = hit_ff; nlen_wd = 5'(ncount);
      buf_pos = c_ff[PosW-1:0];
      rd_idx = ridx_ff; rd_pos = rpos_ff[PosW-1:0];
      if (rsp_v_ff && rsp_tready) rsp_v_in = 1'b0;
      case (state_ff)
         ble_dedup_pkg::S_IDLE: begin
            if (accept) begin
               addr_in = s_addr; rssi_in = s_rssi; rpos_in = s_rpos;
               ridx_in = s_ridx[IdxW-1:0]; k_in = '0;
               case (cmd)
                  ble_dedup_pkg::CMD_CLEAR: count_in = '0;
                  ble_dedup_pkg::CMD_READ: begin
                     state_in = ble_dedup_pkg::S_READ;
                     st_in = ({1'b0, s_ridx} < 6'(count_ff)) ?
                        ble_dedup_pkg::ST_READ : ble_dedup_pkg::ST_EMPTY;
                  end
                  ble_dedup_pkg::CMD_ADV: if (req_tlast) state_in = ble_dedup_pkg::S_SEARCH;
                  default: ;
               endcase
            end
         end
         ble_dedup_pkg::S_SEARCH: begin
            // k_ff counts rotations; cell 0 holds entry k_ff.
            if (k_ff < count_ff && cell_addr[0] == addr_ff) begin
               hit_in = k_ff[IdxW-1:0];
               st_in = ble_dedup_pkg::ST_UPDATED;
               ctl.shift = 1'b1; // finish full rotation by continuing
               k_in = k_ff + 1'b1;
               state_in = ble_dedup_pkg::S_COPY;
            end else if (k_ff == CntW'(MaxDevices - 1) || k_ff >= count_ff) begin
               if (k_ff < count_ff) begin
                  ctl.shift = 1'b1; k_in = k_ff + 1'b1;
               end
               if (count_ff < CntW'(MaxDevices)) begin
                  st_in = ble_dedup_pkg::ST_INSERTED;
                  hit_in = count_ff[IdxW-1:0];
               end else begin
                  st_in = ble_dedup_pkg::ST_DROPPED;
               end
               state_in = ble_dedup_pkg::S_COPY;
            end else begin
               ctl.shift = 1'b1; k_in = k_ff + 1'b1;
            end
            c_in = '0;
         end
         ble_dedup_pkg::S_COPY: begin
            // Bring the chain back to its home rotation first.
            if (k_ff != '0 && k_ff != CntW'(MaxDevices)) begin
               ctl.shift = 1'b1; k_in = k_ff + 1'b1;
            end else begin
               k_in = '0;
               if (c_ff == '0) begin
                  if (st_ff != ble_dedup_pkg::ST_DROPPED) begin
                     rssi_we = 1'b1;
                     if (st_ff == ble_dedup_pkg::ST_INSERTED || ncount != '0) nlen_we = 1'b1;
                     if (st_ff == ble_dedup_pkg::ST_INSERTED) begin
                        ctl.load_addr = 1'b1;
                        count_in = count_ff + 1'b1;
                     end
                  end
                  // A dropped report writes no name and goes straight to the response.
                  c_in = (st_ff == ble_dedup_pkg::ST_DROPPED) ?
                     (PosW+1)'(NameBytes) + 1'b1 : c_ff + 1'b1;
                  buf_pos = '0;
               end else if (c_ff <= (PosW+1)'(NameBytes)) begin
                  // buf_byte holds name byte c_ff-1.
                  name_we = (c_ff - 1'b1) < ncount;
                  buf_pos = PosW'(c_ff);
                  c_in = c_ff + 1'b1;
               end else begin
                  rd_idx = hit_ff;
                  state_in = ble_dedup_pkg::S_READ;
                  ridx_in = hit_ff;
               end
            end
         end
         ble_dedup_pkg::S_READ: begin
            state_in = ble_dedup_pkg::S_OUT;
         end
         ble_dedup_pkg::S_OUT: begin
            // Wait here until the response register is free or is emptied this cycle.
            if (!rsp_v_ff || rsp_tready) begin
               rsp_v_in = 1'b1;
               rsp_u_in = st_ff;
               rsp_d_in = '0;
               rsp_d_in[5:0] = 6'(count_ff);
               case (st_ff)
                  ble_dedup_pkg::ST_READ: begin
                     rsp_d_in[53:6] = cell_addr[ridx_ff];
                     rsp_d_in[61:54] = rssi_rd;
                     rsp_d_in[69:62] = ({1'b0, rpos_ff} < 6'(nlen_rd)) ? name_rd : 8'd0;
                     rsp_d_in[74:70] = nlen_rd;
                  end
                  ble_dedup_pkg::ST_EMPTY: ;
                  ble_dedup_pkg::ST_DROPPED: begin
                     rsp_d_in[53:6] = addr_ff;
                     rsp_d_in[61:54] = rssi_ff;
                     rsp_d_in[74:70] = 5'(ncount);
                  end
                  default: begin
                     rsp_d_in[53:6] = addr_ff;
                     rsp_d_in[61:54] = rssi_ff;
                     rsp_d_in[74:70] = nlen_rd;
                  end
               endcase
               if (st_ff == ble_dedup_pkg::ST_UPDATED || st_ff == ble_dedup_pkg::ST_INSERTED ||
                   st_ff == ble_dedup_pkg::ST_DROPPED) begin
                  restart = 1'b1;
               end
               state_in = ble_dedup_pkg::S_IDLE;
            end
         end
         default: state_in = ble_dedup_pkg::S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (rssi_we) rssi_mem[mem_idx] <= rssi_ff;
      if (nlen_we) nlen_mem[mem_idx] <= nlen_wd;
      if (name_we) name_mem[{mem_idx, PosW'(c_ff - 1'b1)}] <= buf_byte;
      rssi_rd <= rssi_mem[rd_idx];
      nlen_rd <= nlen_mem[rd_idx];
      name_rd <= name_mem[{rd_idx, rd_pos}];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ble_dedup_pkg::S_IDLE;
         count_ff <= '0;
         rsp_v_ff <= 1'b0;
         k_ff <= '0;
         c_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         rsp_v_ff <= rsp_v_in;
         k_ff <= k_in;
         c_ff <= c_in;
      end
   end

   always_ff @(posedge clock) begin
      hit_ff <= hit_in; addr_ff <= addr_in; rssi_ff <= rssi_in; rpos_ff <= rpos_in;
      ridx_ff <= ridx_in; st_ff <= st_in; rsp_d_ff <= rsp_d_in; rsp_u_ff <= rsp_u_in;
   end

   assign rsp_tvalid = rsp_v_ff;
   assign rsp_tdata = rsp_d_ff;
   assign rsp_tuser = rsp_u_ff;

`ifndef SYNTHESIS
   a_count_max: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CntW'(MaxDevices)) else $error("device count overflow");
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      state_ff != ble_dedup_pkg::S_IDLE |-> !req_tready) else $error("ready while busy");
   a_rsp_after_out: assert property (@(posedge clock) disable iff (reset)
      state_ff == ble_dedup_pkg::S_OUT |=> rsp_tvalid) else $error("response lost");
`endif

endmodule
